// File: rtl/cpc_pkg.sv
// Shared constants, types and the arctangent table of the coordinate converter.
package cpc_pkg;

	// Fraction bits carried by coordinates inside the rotator.
	localparam int GUARD = 16;
	// Angle register width: a 32-bit turn plus headroom for the rotation residue.
	localparam int ZW = 34;
	// Low slice of the magnitude taken into the first partial product.
	localparam int LO_W = 24;
	// Converged CORDIC gain in Q0.32.
	localparam logic [31:0] GAIN = 32'd2608131496;
	localparam logic signed [ZW-1:0] Z_HALF = 34'sh0_8000_0000;

	// atan(2^-i) in units of 2^-32 turn, rounded to nearest.
	localparam logic [31:0] ATAN [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef enum logic {
		OP_TO_POLAR = 1'b0,
		OP_TO_CART  = 1'b1
	} op_t;

	typedef struct packed {
		op_t  op;
		logic origin;
	} ctl_t;

endpackage

// File: rtl/cpc_in_if.sv
// Operand channel: operation code and two signed operands.
interface cpc_in_if #(
	parameter int DATA_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic signed [DATA_WIDTH-1:0] first_operand;
	logic signed [DATA_WIDTH-1:0] second_operand;

	modport source (output valid, output operation, output first_operand,
		output second_operand, input ready);
	modport sink (input valid, input operation, input first_operand,
		input second_operand, output ready);
endinterface

// File: rtl/cpc_out_if.sv
// Result channel: two signed results one bit wider than the operands.
interface cpc_out_if #(
	parameter int DATA_WIDTH = 16
);
	logic                       valid;
	logic                       ready;
	logic signed [DATA_WIDTH:0] first_result;
	logic signed [DATA_WIDTH:0] second_result;

	modport source (output valid, output first_result, output second_result,
		input ready);
	modport sink (input valid, input first_result, input second_result,
		output ready);
endinterface

// File: rtl/cpc_pre.sv
// Input stage: scales operands and folds them into the rotator's convergence range.
module cpc_pre #(
	parameter int DW = 16,
	parameter int XW = 35
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        operation,
	input  logic signed [DW-1:0]        a,
	input  logic signed [DW-1:0]        b,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [XW-1:0]        x_out,
	output logic signed [XW-1:0]        y_out,
	output logic signed [cpc_pkg::ZW-1:0] z_out,
	output cpc_pkg::ctl_t               ctl_out
);
	import cpc_pkg::*;

	logic                 v_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	ctl_t                 ctl_s1;

	logic signed [XW-1:0] x0, y0, x_nx, y_nx;
	logic signed [ZW-1:0] z_nx;
	logic [31:0]          zb;
	logic                 flip;
	ctl_t                 ctl_nx;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		x0 = XW'(a) <<< GUARD;
		y0 = XW'(b) <<< GUARD;
		flip = b[DW-1] ^ b[DW-2];
		zb = 32'(unsigned'(b)) << (32 - DW);
		ctl_nx.op = op_t'(operation);
		ctl_nx.origin = 1'b0;
		if (ctl_nx.op == OP_TO_POLAR) begin
			ctl_nx.origin = (a == '0) && (b == '0);
			// left half plane: rotate by pi first
			if (a[DW-1]) begin
				x_nx = -x0;
				y_nx = -y0;
				z_nx = Z_HALF;
			end else begin
				x_nx = x0;
				y_nx = y0;
				z_nx = '0;
			end
		end else begin
			// angle outside [-pi/2, pi/2): negate radius, shift by pi
			zb[31] = zb[31] ^ flip;
			x_nx = flip ? -x0 : x0;
			y_nx = '0;
			z_nx = ZW'(signed'(zb));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			z_s1 <= z_nx;
			ctl_s1 <= ctl_nx;
		end
	end

	assign out_valid = v_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;
	assign ctl_out = ctl_s1;
endmodule

// File: rtl/cpc_iter.sv
// One CORDIC micro-rotation stage with its own valid bit.
module cpc_iter #(
	parameter int XW = 35,
	parameter int K = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [XW-1:0]          x_in,
	input  logic signed [XW-1:0]          y_in,
	input  logic signed [cpc_pkg::ZW-1:0] z_in,
	input  cpc_pkg::ctl_t                 ctl_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [XW-1:0]          x_out,
	output logic signed [XW-1:0]          y_out,
	output logic signed [cpc_pkg::ZW-1:0] z_out,
	output cpc_pkg::ctl_t                 ctl_out
);
	import cpc_pkg::*;

	localparam logic signed [ZW-1:0] STEP = ZW'(ATAN[5'(K)]);

	logic                 v_s1;
	logic signed [XW-1:0] x_s1, y_s1;
	logic signed [ZW-1:0] z_s1;
	ctl_t                 ctl_s1;

	logic                 ccw;
	logic signed [XW-1:0] dx, dy, x_nx, y_nx;
	logic signed [ZW-1:0] z_nx;

	assign in_ready = !v_s1 || out_ready;

	always_comb begin
		// vectoring drives y to zero, rotation drives the residual angle to zero
		ccw = (ctl_in.op == OP_TO_CART) ? !z_in[ZW-1] : y_in[XW-1];
		dx = y_in >>> K;
		dy = x_in >>> K;
		x_nx = ccw ? x_in - dx : x_in + dx;
		y_nx = ccw ? y_in + dy : y_in - dy;
		z_nx = ccw ? z_in - STEP : z_in + STEP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			x_s1 <= x_nx;
			y_s1 <= y_nx;
			z_s1 <= z_nx;
			ctl_s1 <= ctl_in;
		end
	end

	assign out_valid = v_s1;
	assign x_out = x_s1;
	assign y_out = y_s1;
	assign z_out = z_s1;
	assign ctl_out = ctl_s1;
endmodule

// File: rtl/cpc_scale.sv
// Gain compensation, angle rounding and the output register.
module cpc_scale #(
	parameter int DW = 16,
	parameter int XW = 35
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [XW-1:0]          x_in,
	input  logic signed [XW-1:0]          y_in,
	input  logic signed [cpc_pkg::ZW-1:0] z_in,
	input  cpc_pkg::ctl_t                 ctl_in,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [DW:0]            first_result,
	output logic signed [DW:0]            second_result
);
	import cpc_pkg::*;

	localparam int HW = XW - LO_W;
	localparam int SW = XW + 33;
	localparam int PW = SW - 48;
	localparam int SH = 32 - DW;
	localparam logic [32:0] HALF = (DW < 32) ? (33'd1 << (31 - DW)) : 33'd0;
	// rounding of the gain product and of the guard bits, merged into one add
	localparam logic [SW-1:0] ROUND_C = (SW'(1) << 47) | (SW'(1) << 31);

	logic rdy1, rdy2, rdy3, rdy4;
	logic v_s1, v_s2, v_s3, v_s4;

	logic [XW-1:0]    mx_s1, my_s1;
	logic             nx_s1, ny_s1, nx_s2, ny_s2, nx_s3, ny_s3;
	logic [DW:0]      ang_s1, ang_s2, ang_s3;
	ctl_t             ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [LO_W+31:0] plx_s2, ply_s2;
	logic [HW+31:0]   phx_s2, phy_s2;
	logic [PW-1:0]    px_s3, py_s3;
	logic signed [DW:0] first_s4, second_s4;

	logic [32:0]     tsum;
	logic [31:0]     tw;
	logic [DW-1:0]   t;
	logic [DW:0]     ang_nx;
	logic [SW-1:0]   sumx, sumy;
	logic signed [PW-1:0] fx, fy;

	assign rdy4 = !v_s4 || out_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_comb begin
		tsum = {1'b0, z_in[31:0]} + HALF;
		tw = 32'(tsum >> SH);
		t = tw[DW-1:0];
		// +pi stays positive, everything above it wraps negative
		ang_nx = ctl_in.origin ? '0 : {t[DW-1] & (|t[DW-2:0]), t};
	end

	always_comb begin
		sumx = (SW'(phx_s2) << LO_W) + SW'(plx_s2) + ROUND_C;
		sumy = (SW'(phy_s2) << LO_W) + SW'(ply_s2) + ROUND_C;
		fx = nx_s3 ? -signed'(px_s3) : signed'(px_s3);
		fy = ny_s3 ? -signed'(py_s3) : signed'(py_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			mx_s1 <= x_in[XW-1] ? unsigned'(-x_in) : unsigned'(x_in);
			my_s1 <= y_in[XW-1] ? unsigned'(-y_in) : unsigned'(y_in);
			nx_s1 <= x_in[XW-1];
			ny_s1 <= y_in[XW-1];
			ang_s1 <= ang_nx;
			ctl_s1 <= ctl_in;
		end
		if (rdy2) begin
			plx_s2 <= mx_s1[LO_W-1:0] * GAIN;
			ply_s2 <= my_s1[LO_W-1:0] * GAIN;
			phx_s2 <= mx_s1[XW-1:LO_W] * GAIN;
			phy_s2 <= my_s1[XW-1:LO_W] * GAIN;
			nx_s2 <= nx_s1;
			ny_s2 <= ny_s1;
			ang_s2 <= ang_s1;
			ctl_s2 <= ctl_s1;
		end
		if (rdy3) begin
			px_s3 <= sumx[SW-1:48];
			py_s3 <= sumy[SW-1:48];
			nx_s3 <= nx_s2;
			ny_s3 <= ny_s2;
			ang_s3 <= ang_s2;
			ctl_s3 <= ctl_s2;
		end
		if (rdy4) begin
			first_s4 <= fx[DW:0];
			second_s4 <= (ctl_s3.op == OP_TO_CART) ? fy[DW:0] : signed'(ang_s3);
			ctl_s4 <= ctl_s3;
		end
	end

	assign out_valid = v_s4;
	assign first_result = first_s4;
	assign second_result = second_s4;

	// a radius never comes out negative
	a_radius_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ctl_s4.op == OP_TO_POLAR |-> !first_s4[DW])
		else $error("negative radius");

	a_origin_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && ctl_s4.origin |-> first_s4 == '0 && second_s4 == '0)
		else $error("origin did not give zero result");

	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !rdy4 |=> v_s3 && $stable(px_s3) && $stable(py_s3))
		else $error("stalled product stage changed");
endmodule

// File: rtl/cartesian_polar_converter_top.sv
// Pipelined CORDIC converter between Cartesian and polar coordinates. One operand
// word is taken per clock while the result channel is ready, and every word yields
// one result word. The pipeline has one input stage that folds the operands into the
// convergence range, one register stage per CORDIC micro-rotation, and four stages
// for magnitude, gain multiply, rounding and the output register. Each stage has its
// own valid bit and is refilled as soon as its word moves on, so a stalled result
// channel blocks the operand channel only once every stage is occupied. Angles are
// binary: 2^(DATA_WIDTH-1) is pi, and +pi is reported as a positive value.
module cartesian_polar_converter_top #(
	parameter int ITERATIONS = 16,
	parameter int DATA_WIDTH = 16
) (
	input logic clk,
	input logic arst_n,
	cpc_in_if.sink   arg,
	cpc_out_if.source res
);
	import cpc_pkg::*;

	localparam int XW = DATA_WIDTH + GUARD + 3;

	logic                 vld_c [ITERATIONS+1];
	logic                 rdy_c [ITERATIONS+1];
	logic signed [XW-1:0] x_c   [ITERATIONS+1];
	logic signed [XW-1:0] y_c   [ITERATIONS+1];
	logic signed [ZW-1:0] z_c   [ITERATIONS+1];
	ctl_t                 ctl_c [ITERATIONS+1];

	cpc_pre #(
		.DW (DATA_WIDTH),
		.XW (XW)
	) u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (arg.valid),
		.in_ready  (arg.ready),
		.operation (arg.operation),
		.a         (arg.first_operand),
		.b         (arg.second_operand),
		.out_valid (vld_c[0]),
		.out_ready (rdy_c[0]),
		.x_out     (x_c[0]),
		.y_out     (y_c[0]),
		.z_out     (z_c[0]),
		.ctl_out   (ctl_c[0])
	);

	for (genvar k = 0; k < ITERATIONS; k++) begin : g_iter
		cpc_iter #(
			.XW (XW),
			.K  (k)
		) u_iter (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_c[k]),
			.in_ready  (rdy_c[k]),
			.x_in      (x_c[k]),
			.y_in      (y_c[k]),
			.z_in      (z_c[k]),
			.ctl_in    (ctl_c[k]),
			.out_valid (vld_c[k+1]),
			.out_ready (rdy_c[k+1]),
			.x_out     (x_c[k+1]),
			.y_out     (y_c[k+1]),
			.z_out     (z_c[k+1]),
			.ctl_out   (ctl_c[k+1])
		);
	end

	cpc_scale #(
		.DW (DATA_WIDTH),
		.XW (XW)
	) u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (vld_c[ITERATIONS]),
		.in_ready      (rdy_c[ITERATIONS]),
		.x_in          (x_c[ITERATIONS]),
		.y_in          (y_c[ITERATIONS]),
		.z_in          (z_c[ITERATIONS]),
		.ctl_in        (ctl_c[ITERATIONS]),
		.out_valid     (res.valid),
		.out_ready     (res.ready),
		.first_result  (res.first_result),
		.second_result (res.second_result)
	);
endmodule
